// ===== hdl/umf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umf_pkg
// Shared types and constants of the unique match filter.
// ----------------------------------------------------------------------------
package umf_pkg;

	localparam int FEAT_W           = 13;
	localparam int CNT_W            = 2;
	localparam int TDATA_W          = 32;
	localparam int MAX_FEATURES_DEF = 8192;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	localparam logic [CNT_W-1:0] CNT_ZERO = 2'd0;
	localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
	localparam logic [CNT_W-1:0] CNT_SAT  = 2'd2;

	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [FEAT_W-1:0] partner;
	} entry_t;

endpackage

// ===== hdl/unique_match_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_match_filter_top
// Match table: inserts count pairs per second-image feature, queries report
// and clear uniqueness. A query result passes the s1 stage registers and
// then the output register. Throughput: one item per cycle while results are
// taken; one read and one write of the table memory per cycle set it.
// Reset: control clears at once, then a clearing pass writes zero to every
// table entry, with s_axis_tready low throughout.
// ----------------------------------------------------------------------------
module unique_match_filter_top
	import umf_pkg::*;
#(
	parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,  // first_feature, second_feature
	input  logic               s_axis_tuser,  // command
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,  // partner_feature, queried_feature
	output logic               m_axis_tuser   // is_unique
);

	localparam int AW = $clog2(MAX_FEATURES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_FEATURES - 1);

	entry_t            mem [MAX_FEATURES];
	entry_t            rdata_s1;

	logic              clr_active_q;
	logic [AW-1:0]     clr_addr_q;

	logic              s1_valid_q;
	logic              cmd_s1;
	logic              in_range_s1;
	logic [AW-1:0]     addr_s1;
	logic [FEAT_W-1:0] first_s1;
	logic [FEAT_W-1:0] second_s1;

	logic              fwd_valid_q;
	logic [AW-1:0]     fwd_addr_q;
	entry_t            fwd_data_q;

	logic              out_valid_q;
	logic              out_unique_q;
	logic [FEAT_W-1:0] out_partner_q;
	logic [FEAT_W-1:0] out_queried_q;

	logic [31:0]       key_ext;
	logic              s_accept;
	logic              s1_adv;
	logic              out_load;
	entry_t            cur_s1;
	entry_t            new_s1;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	entry_t            wr_data;

	assign key_ext  = 32'(s_axis_tdata[2*FEAT_W-1:FEAT_W]);
	assign s1_adv   = s1_valid_q && (cmd_s1 == CMD_INSERT || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !clr_active_q && (!s1_valid_q || s1_adv);
	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign out_load = s1_adv && cmd_s1 == CMD_QUERY;

	assign cur_s1 = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rdata_s1;

	always_comb begin
		new_s1 = cur_s1;
		if (cmd_s1 == CMD_QUERY) begin
			new_s1.cnt = CNT_ZERO;
		end else begin
			if (cur_s1.cnt == CNT_ZERO) begin
				new_s1.partner = first_s1;
			end
			if (cur_s1.cnt < CNT_SAT) begin
				new_s1.cnt = cur_s1.cnt + CNT_ONE;
			end
		end
	end

	always_comb begin
		if (clr_active_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en   = s1_adv && in_range_s1;
			wr_addr = addr_s1;
			wr_data = new_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (s_accept) begin
			rdata_s1 <= mem[key_ext[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!s1_valid_q || s1_adv) begin
			s1_valid_q <= s_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1      <= s_axis_tuser;
			in_range_s1 <= key_ext < 32'(MAX_FEATURES);
			addr_s1     <= key_ext[AW-1:0];
			first_s1    <= s_axis_tdata[FEAT_W-1:0];
			second_s1   <= s_axis_tdata[2*FEAT_W-1:FEAT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (clr_active_q) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_unique_q  <= in_range_s1 && cur_s1.cnt == CNT_ONE;
			out_partner_q <= (in_range_s1 && cur_s1.cnt == CNT_ONE) ? cur_s1.partner : '0;
			out_queried_q <= second_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_unique_q;
	assign m_axis_tdata  = {(TDATA_W - 2*FEAT_W)'(0), out_queried_q, out_partner_q};

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !s_axis_tready)
		else $error("transaction accepted during clearing pass");

	a_clear_s1_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(clr_active_q && s1_valid_q))
		else $error("pipeline active during clearing pass");

	a_query_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && cmd_s1 == CMD_QUERY && out_valid_q && !m_axis_tready)
			|=> (s1_valid_q && $stable(addr_s1)))
		else $error("stalled query lost");

	a_partner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[FEAT_W-1:0] == '0))
		else $error("partner nonzero on non-unique result");

endmodule
